// ===== sv/dsc_pkg.sv =====
// Shared types and constants of the delta sample channel.
package dsc_pkg;

	// Request codes carried in req_type
	typedef enum logic [1:0] {
		REQ_TICK       = 2'd0,
		REQ_STATUS     = 2'd1,
		REQ_SOFT_RESET = 2'd2
	} req_code_t;

	// Configuration register indexes
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 16;
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TIMER_PERIOD  = 3'd0,
		CFG_LOOP_ENABLE   = 3'd1,
		CFG_IRQ_ARM       = 3'd2,
		CFG_START_ADDRESS = 3'd3,
		CFG_SAMPLE_BYTES  = 3'd4
	} cfg_index_t;

	// Fixed constants of the channel
	localparam logic [15:0] ADDR_LAST        = 16'hFFFF;
	localparam logic [15:0] ADDR_WRAP        = 16'h8000;
	localparam logic [15:0] START_ADDR_RESET = 16'hC000;
	localparam logic [6:0]  LEVEL_MAX        = 7'd127;
	localparam logic [3:0]  BITS_PER_BYTE    = 4'd8;

	// One request as taken from the input channel
	typedef struct packed {
		logic [1:0] req_type;
		logic       enable;
		logic [7:0] fetched_byte;
	} in_item_t;

	// One result item
	typedef struct packed {
		logic [6:0]  level;
		logic [15:0] fetch_address;
		logic        fetched;
		logic        irq_raise;
		logic        irq_flag;
		logic        active;
	} out_item_t;

	// Configuration register contents
	typedef struct packed {
		logic [8:0]  timer_period;
		logic        loop_enable;
		logic        irq_arm;
		logic [15:0] start_address;
		logic [11:0] sample_bytes;
	} cfg_t;

endpackage

// ===== sv/dsc_if.sv =====
// Channel interfaces: request input, result output and configuration write.
interface dsc_cmd_if;
	logic       valid;
	logic       ready;
	logic [1:0] req_type;
	logic       enable;
	logic [7:0] fetched_byte;

	modport source (output valid, req_type, enable, fetched_byte, input ready);
	modport sink (input valid, req_type, enable, fetched_byte, output ready);
endinterface

interface dsc_res_if;
	logic        valid;
	logic        ready;
	logic [6:0]  level;
	logic [15:0] fetch_address;
	logic        fetched;
	logic        irq_raise;
	logic        irq_flag;
	logic        active;

	modport source (output valid, level, fetch_address, fetched, irq_raise, irq_flag, active,
		input ready);
	modport sink (input valid, level, fetch_address, fetched, irq_raise, irq_flag, active,
		output ready);
endinterface

interface dsc_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [dsc_pkg::CFG_IDX_W-1:0]   index;
	logic [dsc_pkg::CFG_DATA_W-1:0]  data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/dsc_cfg_regs.sv =====
// Configuration register file of the delta sample channel.
module dsc_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_valid,
	input  logic [dsc_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [dsc_pkg::CFG_DATA_W-1:0] wr_data,
	output dsc_pkg::cfg_t                  cfg
);

	dsc_pkg::cfg_t cfg_q;

	// Decode the index and update one register per write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.timer_period  <= '0;
			cfg_q.loop_enable   <= 1'b0;
			cfg_q.irq_arm       <= 1'b0;
			cfg_q.start_address <= dsc_pkg::START_ADDR_RESET;
			cfg_q.sample_bytes  <= '0;
		end else if (wr_valid) begin
			unique case (wr_index)
				dsc_pkg::CFG_TIMER_PERIOD:  cfg_q.timer_period  <= wr_data[8:0];
				dsc_pkg::CFG_LOOP_ENABLE:   cfg_q.loop_enable   <= wr_data[0];
				dsc_pkg::CFG_IRQ_ARM:       cfg_q.irq_arm       <= wr_data[0];
				dsc_pkg::CFG_START_ADDRESS: cfg_q.start_address <= wr_data[15:0];
				dsc_pkg::CFG_SAMPLE_BYTES:  cfg_q.sample_bytes  <= wr_data[11:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== sv/dsc_engine.sv =====
// Channel state registers and the single-pass update for one request.
module dsc_engine (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  dsc_pkg::in_item_t   item,
	input  dsc_pkg::cfg_t       cfg,
	output dsc_pkg::out_item_t  result
);

	logic        enabled_q;
	logic        buf_empty_q;
	logic [7:0]  buf_byte_q;
	logic [15:0] addr_q;
	logic [11:0] bytes_left_q;
	logic [8:0]  timer_q;
	logic [7:0]  shift_q;
	logic [3:0]  bits_left_q;
	logic        silent_q;
	logic [6:0]  level_q;
	logic        irq_pending_q;
	logic        irq_already_q;

	logic        enabled_d;
	logic        buf_empty_d;
	logic [7:0]  buf_byte_d;
	logic [15:0] addr_d;
	logic [11:0] bytes_left_d;
	logic [8:0]  timer_d;
	logic [7:0]  shift_d;
	logic [3:0]  bits_left_d;
	logic        silent_d;
	logic [6:0]  level_d;
	logic        irq_pending_d;
	logic        irq_already_d;
	logic        got;
	logic        raised;
	logic [7:0]  level_up;
	logic        status_en;

	// Work out the next state for the request in the input register
	always_comb begin
		enabled_d     = enabled_q;
		buf_empty_d   = buf_empty_q;
		buf_byte_d    = buf_byte_q;
		addr_d        = addr_q;
		bytes_left_d  = bytes_left_q;
		timer_d       = timer_q;
		shift_d       = shift_q;
		bits_left_d   = bits_left_q;
		silent_d      = silent_q;
		level_d       = level_q;
		irq_pending_d = irq_pending_q;
		irq_already_d = irq_already_q;
		got           = 1'b0;
		raised        = 1'b0;
		level_up      = {1'b0, level_q} + 8'd2;
		status_en     = item.enable;

		case (item.req_type) inside
			dsc_pkg::REQ_TICK: begin
				// Refill the sample buffer
				if (enabled_q && buf_empty_q) begin
					if (bytes_left_q != '0) begin
						got           = 1'b1;
						buf_byte_d    = item.fetched_byte;
						buf_empty_d   = 1'b0;
						bytes_left_d  = bytes_left_q - 12'd1;
						addr_d        = (addr_q == dsc_pkg::ADDR_LAST) ? dsc_pkg::ADDR_WRAP
							: addr_q + 16'd1;
						irq_already_d = 1'b0;
					end
					if (bytes_left_d == '0) begin
						if (cfg.loop_enable) begin
							addr_d       = cfg.start_address;
							bytes_left_d = cfg.sample_bytes;
						end else if (cfg.irq_arm && !irq_already_d) begin
							irq_pending_d = 1'b1;
							irq_already_d = 1'b1;
							raised        = 1'b1;
						end
					end
				end
				// Advance the rate timer, shift one bit on expiry
				if (timer_q != '0) begin
					timer_d = timer_q - 9'd1;
				end else begin
					timer_d = cfg.timer_period;
					if (bits_left_q != '0) begin
						if (!silent_q) begin
							if (shift_q[0]) begin
								level_d = (level_up > {1'b0, dsc_pkg::LEVEL_MAX})
									? dsc_pkg::LEVEL_MAX : level_up[6:0];
							end else if (level_q > 7'd1) begin
								level_d = level_q - 7'd2;
							end
							shift_d = shift_q >> 1;
						end
						bits_left_d = bits_left_q - 4'd1;
					end
					if (bits_left_d == '0) begin
						if (buf_empty_d) begin
							silent_d = 1'b1;
						end else begin
							shift_d     = buf_byte_d;
							buf_empty_d = 1'b1;
							silent_d    = 1'b0;
						end
						bits_left_d = dsc_pkg::BITS_PER_BYTE;
					end
				end
			end
			dsc_pkg::REQ_STATUS, dsc_pkg::REQ_SOFT_RESET: begin
				// Enable or disable, clear the interrupt; a soft reset disables and keeps only the level's low bit
				if (item.req_type == dsc_pkg::REQ_SOFT_RESET) begin
					status_en = 1'b0;
				end
				enabled_d = status_en;
				if (status_en && bytes_left_q == '0) begin
					bytes_left_d = cfg.sample_bytes;
					addr_d       = cfg.start_address;
				end else if (!status_en) begin
					bytes_left_d = '0;
				end
				irq_pending_d = 1'b0;
				if (item.req_type == dsc_pkg::REQ_SOFT_RESET) begin
					level_d = {6'd0, level_q[0]};
				end
			end
			default: ;
		endcase
	end

	// Hold state unless a request is processed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q     <= 1'b0;
			buf_empty_q   <= 1'b1;
			buf_byte_q    <= '0;
			addr_q        <= '0;
			bytes_left_q  <= '0;
			timer_q       <= '0;
			shift_q       <= '0;
			bits_left_q   <= '0;
			silent_q      <= 1'b1;
			level_q       <= '0;
			irq_pending_q <= 1'b0;
			irq_already_q <= 1'b0;
		end else if (step) begin
			enabled_q     <= enabled_d;
			buf_empty_q   <= buf_empty_d;
			buf_byte_q    <= buf_byte_d;
			addr_q        <= addr_d;
			bytes_left_q  <= bytes_left_d;
			timer_q       <= timer_d;
			shift_q       <= shift_d;
			bits_left_q   <= bits_left_d;
			silent_q      <= silent_d;
			level_q       <= level_d;
			irq_pending_q <= irq_pending_d;
			irq_already_q <= irq_already_d;
		end
	end

	// Result reflects the state after this request
	always_comb begin
		result.level         = level_d;
		result.fetch_address = addr_d;
		result.fetched       = got;
		result.irq_raise     = raised;
		result.irq_flag      = irq_pending_d;
		result.active        = (bytes_left_d != '0);
	end

	// A disabled channel never has bytes outstanding
	a_disabled_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!enabled_q |-> bytes_left_q == '0)
		else $error("disabled channel with bytes left");

	// Bit counter never runs past one byte
	a_bits_range: assert property (@(posedge clk) disable iff (!arst_n)
		bits_left_q <= dsc_pkg::BITS_PER_BYTE)
		else $error("bit counter out of range");

	// A raised interrupt is pending after the step
	a_irq_sets_flag: assert property (@(posedge clk) disable iff (!arst_n)
		step && raised |=> irq_pending_q && irq_already_q)
		else $error("interrupt raised without pending flag");

	// A fetch only happens on an enabled channel with an empty buffer
	a_fetch_cond: assert property (@(posedge clk) disable iff (!arst_n)
		got |-> enabled_q && buf_empty_q && bytes_left_q != '0)
		else $error("fetch outside an empty enabled buffer");

endmodule

// ===== sv/delta_sample_channel.sv =====
// Top level of the delta sample channel: handshakes, input and result registers.
//
//  channel | role   | payload                                            | accepted when
//  cmd     | sink   | req_type, enable, fetched_byte                     | valid && ready
//  res     | source | level, fetch_address, fetched, irq_raise, irq_flag, | valid && ready
//          |        | active                                             |
//  cfg     | sink   | index, data                                        | valid && ready
//
// One request per clock sustained while results are taken; a result is offered
// from the result register once its request has left the input register. The state
// update is one pass of logic between the two registers, so requests chain back to back.
// arst_n resets the state, the configuration and both valid flags.
// A held result stalls the input register, and ready drops once both are full.
// cfg is always ready; writes belong to idle periods.
module delta_sample_channel (
	input  logic       clk,
	input  logic       arst_n,
	dsc_cmd_if.sink    cmd,
	dsc_res_if.source  res,
	dsc_cfg_if.sink    cfg
);

	dsc_pkg::cfg_t      cfg_val;
	dsc_pkg::in_item_t  item_s1;
	dsc_pkg::out_item_t step_result;
	dsc_pkg::out_item_t result_s2;
	logic               valid_s1;
	logic               valid_s2;
	logic               adv_s2;
	logic               adv_s1;

	assign cfg.ready = 1'b1;

	dsc_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (cfg.valid),
		.wr_index (cfg.index),
		.wr_data  (cfg.data),
		.cfg      (cfg_val)
	);

	// Pipeline advance: result slot frees when empty or taken
	assign adv_s2    = !valid_s2 || res.ready;
	assign adv_s1    = !valid_s1 || adv_s2;
	assign cmd.ready = adv_s1;

	dsc_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (valid_s1 && adv_s2),
		.item   (item_s1),
		.cfg    (cfg_val),
		.result (step_result)
	);

	// Valid flags of both stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= cmd.valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// Capture the request and the result
	always_ff @(posedge clk) begin
		if (adv_s1 && cmd.valid) begin
			item_s1.req_type     <= cmd.req_type;
			item_s1.enable       <= cmd.enable;
			item_s1.fetched_byte <= cmd.fetched_byte;
		end
		if (adv_s2 && valid_s1) begin
			result_s2 <= step_result;
		end
	end

	assign res.valid         = valid_s2;
	assign res.level         = result_s2.level;
	assign res.fetch_address = result_s2.fetch_address;
	assign res.fetched       = result_s2.fetched;
	assign res.irq_raise     = result_s2.irq_raise;
	assign res.irq_flag      = result_s2.irq_flag;
	assign res.active        = result_s2.active;

	// Input back-pressure only comes from a held result
	a_stall_source: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.ready |-> valid_s1 && valid_s2 && !res.ready)
		else $error("input stalled without a held result");

	// An accepted request occupies the input register next cycle
	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.valid && cmd.ready |=> valid_s1)
		else $error("accepted request lost");

	// A blocked input register keeps its request
	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv_s2 |=> valid_s1 && $stable(item_s1))
		else $error("stalled request dropped");

endmodule

// ===== test/delta_sample_channel_test.sv =====
// Self-checking testbench of the delta sample channel: directed table, then random phases.
module delta_sample_channel_test;

	// Request code that the block must ignore
	localparam logic [1:0] REQ_UNUSED = 2'd3;

	// Receiver stall patterns
	typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

	// Channel state as the predictor tracks it
	typedef struct packed {
		logic        enabled;
		logic        buf_empty;
		logic [7:0]  buf_byte;
		logic [15:0] addr;
		logic [11:0] remaining;
		logic [8:0]  timer;
		logic [7:0]  shreg;
		logic [3:0]  bits;
		logic        silent;
		logic [6:0]  level;
		logic        irq_pend;
		logic        irq_done;
	} chan_state_t;

	localparam chan_state_t CHAN_AT_RESET = '{1'b0, 1'b1, 8'h00, 16'h0000, 12'h000, 9'h000,
		8'h00, 4'h0, 1'b1, 7'd0, 1'b0, 1'b0};
	localparam dsc_pkg::cfg_t CFG_AT_RESET = '{9'd0, 1'b0, 1'b0, dsc_pkg::START_ADDR_RESET,
		12'd0};
	localparam dsc_pkg::out_item_t NO_PIN = '0;

	// One row of the directed table: a register write or a request
	typedef struct {
		bit                  is_cfg;
		dsc_pkg::cfg_index_t idx;
		logic [15:0]         wdata;
		dsc_pkg::in_item_t   req;
		bit                  pinned;
		dsc_pkg::out_item_t  pin;
	} step_row_t;

	localparam int N_DIRECTED = 36;
	step_row_t directed_rows [N_DIRECTED] = '{
		// reset settings, channel disabled
		'{1'b0, dsc_pkg::CFG_TIMER_PERIOD, 16'h0, '{dsc_pkg::REQ_TICK, 1'b0, 8'hFF}, 1'b1,
			'{7'd0, 16'h0000, 1'b0, 1'b0, 1'b0, 1'b0}},
		'{1'b0, dsc_pkg::CFG_TIMER_PERIOD, 16'h0, '{REQ_UNUSED, 1'b1, 8'hAA}, 1'b1,
			'{7'd0, 16'h0000, 1'b0, 1'b0, 1'b0, 1'b0}},
		'{1'b0, dsc_pkg::CFG_TIMER_PERIOD, 16'h0, '{dsc_pkg::REQ_STATUS, 1'b1, 8'h00}, 1'b1,
			'{7'd0, 16'hC000, 1'b0, 1'b0, 1'b0, 1'b0}},
		'{1'b0, dsc_pkg::CFG_TIMER_PERIOD, 16'h0, '{dsc_pkg::REQ_SOFT_RESET, 1'b1, 8'h55},
			1'b1, '{7'd0, 16'hC000, 1'b0, 1'b0, 1'b0, 1'b0}},
		// two-byte sample at the top of memory, interrupt on
		'{1'b1, dsc_pkg::CFG_TIMER_PERIOD, 16'd0, '0, 1'b0, NO_PIN},
		'{1'b1, dsc_pkg::CFG_LOOP_ENABLE, 16'd0, '0, 1'b0, NO_PIN},
		'{1'b1, dsc_pkg::CFG_IRQ_ARM, 16'd1, '0, 1'b0, NO_PIN},
		'{1'b1, dsc_pkg::CFG_START_ADDRESS, 16'hFFFF, '0, 1'b0, NO_PIN},
		'{1'b1, dsc_pkg::CFG_SAMPLE_BYTES, 16'd2, '0, 1'b0, NO_PIN},
		'{1'b0, dsc_pkg::CFG_TIMER_PERIOD, 16'h0, '{dsc_pkg::REQ_STATUS, 1'b1, 8'h00}, 1'b1,
			'{7'd0, 16'hFFFF, 1'b0, 1'b0, 1'b0, 1'b1}},
		// first fetch wraps the address
		'{1'b0, dsc_pkg::CFG_TIMER_PERIOD, 16'h0, '{dsc_pkg::REQ_TICK, 1'b0, 8'hFF}, 1'b1,
			'{7'd0, 16'h8000, 1'b1, 1'b0, 1'b0, 1'b1}},
		'{1'b0, dsc_pkg::CFG_TIMER_PERIOD, 16'h0, '{dsc_pkg::REQ_TICK, 1'b1, 8'h00}, 1'b0,
			NO_PIN},
		'{1'b0, dsc_pkg::CFG_TIMER_PERIOD, 16'h0, '{dsc_pkg::REQ_TICK, 1'b0, 8'h00}, 1'b0,
			NO_PIN},
		'{1'b0, dsc_pkg::CFG_TIMER_PERIOD, 16'h0, '{dsc_pkg::REQ_TICK, 1'b0, 8'h00}, 1'b0,
			NO_PIN},
		'{1'b0, dsc_pkg::CFG_TIMER_PERIOD, 16'h0, '{dsc_pkg::REQ_TICK, 1'b0, 8'h00}, 1'b0,
			NO_PIN},
		'{1'b0, dsc_pkg::CFG_TIMER_PERIOD, 16'h0, '{dsc_pkg::REQ_TICK, 1'b0, 8'h00}, 1'b0,
			NO_PIN},
		'{1'b0, dsc_pkg::CFG_TIMER_PERIOD, 16'h0, '{dsc_pkg::REQ_TICK, 1'b0, 8'h00}, 1'b0,
			NO_PIN},
		'{1'b0, dsc_pkg::CFG_TIMER_PERIOD, 16'h0, '{dsc_pkg::REQ_TICK, 1'b0, 8'h00}, 1'b0,
			NO_PIN},
		// last byte moves into the shift register; a disable then clears the interrupt
		'{1'b0, dsc_pkg::CFG_TIMER_PERIOD, 16'h0, '{dsc_pkg::REQ_TICK, 1'b0, 8'h5A}, 1'b0,
			NO_PIN},
		'{1'b0, dsc_pkg::CFG_TIMER_PERIOD, 16'h0, '{dsc_pkg::REQ_STATUS, 1'b0, 8'h00}, 1'b0,
			NO_PIN},
		// zero-length sample with looping
		'{1'b1, dsc_pkg::CFG_LOOP_ENABLE, 16'd1, '0, 1'b0, NO_PIN},
		'{1'b1, dsc_pkg::CFG_SAMPLE_BYTES, 16'd0, '0, 1'b0, NO_PIN},
		'{1'b1, dsc_pkg::CFG_START_ADDRESS, 16'h8000, '0, 1'b0, NO_PIN},
		'{1'b0, dsc_pkg::CFG_TIMER_PERIOD, 16'h0, '{dsc_pkg::REQ_STATUS, 1'b1, 8'h00}, 1'b0,
			NO_PIN},
		'{1'b0, dsc_pkg::CFG_TIMER_PERIOD, 16'h0, '{dsc_pkg::REQ_TICK, 1'b0, 8'hFF}, 1'b0,
			NO_PIN},
		'{1'b0, dsc_pkg::CFG_TIMER_PERIOD, 16'h0, '{dsc_pkg::REQ_SOFT_RESET, 1'b0, 8'h00},
			1'b0, NO_PIN},
		// largest period and length, address zero
		'{1'b1, dsc_pkg::CFG_TIMER_PERIOD, 16'd511, '0, 1'b0, NO_PIN},
		'{1'b1, dsc_pkg::CFG_SAMPLE_BYTES, 16'd4095, '0, 1'b0, NO_PIN},
		'{1'b1, dsc_pkg::CFG_START_ADDRESS, 16'h0000, '0, 1'b0, NO_PIN},
		'{1'b1, dsc_pkg::CFG_LOOP_ENABLE, 16'd0, '0, 1'b0, NO_PIN},
		'{1'b1, dsc_pkg::CFG_IRQ_ARM, 16'd0, '0, 1'b0, NO_PIN},
		'{1'b0, dsc_pkg::CFG_TIMER_PERIOD, 16'h0, '{dsc_pkg::REQ_STATUS, 1'b1, 8'h00}, 1'b0,
			NO_PIN},
		'{1'b0, dsc_pkg::CFG_TIMER_PERIOD, 16'h0, '{dsc_pkg::REQ_TICK, 1'b0, 8'hFF}, 1'b0,
			NO_PIN},
		'{1'b0, dsc_pkg::CFG_TIMER_PERIOD, 16'h0, '{dsc_pkg::REQ_TICK, 1'b1, 8'h80}, 1'b0,
			NO_PIN},
		'{1'b0, dsc_pkg::CFG_TIMER_PERIOD, 16'h0, '{dsc_pkg::REQ_STATUS, 1'b0, 8'h00}, 1'b0,
			NO_PIN},
		'{1'b0, dsc_pkg::CFG_TIMER_PERIOD, 16'h0, '{REQ_UNUSED, 1'b0, 8'h00}, 1'b0, NO_PIN}
	};

	logic clk = 1'b0;
	logic arst_n;

	dsc_cmd_if cmd_ch ();
	dsc_res_if res_ch ();
	dsc_cfg_if cfg_ch ();

	delta_sample_channel DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.res    (res_ch),
		.cfg    (cfg_ch)
	);

	// Predictor state and the results still owed by the block
	chan_state_t        chan = CHAN_AT_RESET;
	dsc_pkg::cfg_t      shadow = CFG_AT_RESET;
	dsc_pkg::out_item_t results_due[$];

	// Typed expectation that travels with the request on the wire
	logic               pin_on;
	dsc_pkg::out_item_t pin_value;

	int mismatches = 0;
	int requests_taken = 0;
	int results_checked = 0;
	int fetch_count = 0;
	int irq_count = 0;
	int phases_run = 0;
	bit peak_seen = 1'b0;
	int burst_left = 0;
	int holds_asked = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Apply the enable bit of a status write
	function automatic void apply_enable(logic en);
		chan.enabled = en;
		if (en && chan.remaining == 12'd0) begin
			chan.remaining = shadow.sample_bytes;
			chan.addr = shadow.start_address;
		end else if (!en) begin
			chan.remaining = 12'd0;
		end
		chan.irq_pend = 1'b0;
	endfunction

	// Advance the channel by one request and return the result it should report
	function automatic dsc_pkg::out_item_t predict_request(dsc_pkg::in_item_t rq);
		dsc_pkg::out_item_t r;
		int lv;
		r = '0;
		case (rq.req_type)
			dsc_pkg::REQ_TICK: begin
				// refill an empty buffer
				if (chan.enabled && chan.buf_empty) begin
					if (chan.remaining != 12'd0) begin
						r.fetched = 1'b1;
						chan.buf_byte = rq.fetched_byte;
						chan.buf_empty = 1'b0;
						chan.remaining = chan.remaining - 12'd1;
						chan.addr = (chan.addr == dsc_pkg::ADDR_LAST) ? dsc_pkg::ADDR_WRAP
							: chan.addr + 16'd1;
						chan.irq_done = 1'b0;
					end
					if (chan.remaining == 12'd0) begin
						if (shadow.loop_enable) begin
							chan.addr = shadow.start_address;
							chan.remaining = shadow.sample_bytes;
						end else if (shadow.irq_arm && !chan.irq_done) begin
							chan.irq_pend = 1'b1;
							chan.irq_done = 1'b1;
							r.irq_raise = 1'b1;
						end
					end
				end
				// rate timer: shift one bit on expiry
				if (chan.timer != 9'd0) begin
					chan.timer = chan.timer - 9'd1;
				end else begin
					chan.timer = shadow.timer_period;
					if (chan.bits != 4'd0) begin
						if (!chan.silent) begin
							lv = int'(chan.level);
							if (chan.shreg[0])
								lv = (lv + 2 > int'(dsc_pkg::LEVEL_MAX))
									? int'(dsc_pkg::LEVEL_MAX) : lv + 2;
							else if (lv > 1)
								lv = lv - 2;
							chan.level = lv[6:0];
							chan.shreg = chan.shreg >> 1;
						end
						chan.bits = chan.bits - 4'd1;
					end
					if (chan.bits == 4'd0) begin
						if (chan.buf_empty) begin
							chan.silent = 1'b1;
						end else begin
							chan.shreg = chan.buf_byte;
							chan.buf_empty = 1'b1;
							chan.silent = 1'b0;
						end
						chan.bits = dsc_pkg::BITS_PER_BYTE;
					end
				end
			end
			dsc_pkg::REQ_STATUS: apply_enable(rq.enable);
			dsc_pkg::REQ_SOFT_RESET: begin
				apply_enable(1'b0);
				chan.level = chan.level & 7'd1;
			end
			default: ;
		endcase
		r.level = chan.level;
		r.fetch_address = chan.addr;
		r.irq_flag = chan.irq_pend;
		r.active = (chan.remaining != 12'd0);
		return r;
	endfunction

	function automatic void check_field(string what, int want, int got);
		if (want != got) begin
			$display("%0t: %s expected %0h actual %0h", $time, what, want, got);
			mismatches++;
		end
	endfunction

	// Offer one request, idling between bursts, and hold until it is taken
	task automatic send_request(input dsc_pkg::in_item_t rq, input bit pinned,
		input dsc_pkg::out_item_t pv);
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
				: $urandom_range(1, 12);
			cmd_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		burst_left--;
		cmd_ch.valid <= 1'b1;
		cmd_ch.req_type <= rq.req_type;
		cmd_ch.enable <= rq.enable;
		cmd_ch.fetched_byte <= rq.fetched_byte;
		pin_on <= pinned;
		pin_value <= pv;
		do @(posedge clk); while (!cmd_ch.ready);
	endtask

	task automatic write_register(input dsc_pkg::cfg_index_t idx, input logic [15:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	// Stop offering and hold until every owed result is back
	task automatic wait_drain();
		cmd_ch.valid <= 1'b0;
		@(posedge clk);
		while (results_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Observe all three channels: configuration, accepted requests, results
	always @(posedge clk) begin : observe
		dsc_pkg::out_item_t want;
		dsc_pkg::in_item_t taken;
		if (arst_n) begin
			if (cfg_ch.valid && cfg_ch.ready) begin
				case (cfg_ch.index)
					dsc_pkg::CFG_TIMER_PERIOD:  shadow.timer_period = cfg_ch.data[8:0];
					dsc_pkg::CFG_LOOP_ENABLE:   shadow.loop_enable = cfg_ch.data[0];
					dsc_pkg::CFG_IRQ_ARM:       shadow.irq_arm = cfg_ch.data[0];
					dsc_pkg::CFG_START_ADDRESS: shadow.start_address = cfg_ch.data;
					dsc_pkg::CFG_SAMPLE_BYTES:  shadow.sample_bytes = cfg_ch.data[11:0];
					default: ;
				endcase
			end
			if (cmd_ch.valid && cmd_ch.ready) begin
				taken = '{cmd_ch.req_type, cmd_ch.enable, cmd_ch.fetched_byte};
				want = predict_request(taken);
				if (pin_on)
					want = pin_value;
				results_due.push_back(want);
				requests_taken++;
			end
			if (res_ch.valid && res_ch.ready) begin
				if (results_due.size() == 0) begin
					$display("%0t: result with nothing expected, level %0h address %0h",
						$time, res_ch.level, res_ch.fetch_address);
					mismatches++;
				end else begin
					want = results_due.pop_front();
					check_field("level", want.level, res_ch.level);
					check_field("fetch_address", want.fetch_address, res_ch.fetch_address);
					check_field("fetched", want.fetched, res_ch.fetched);
					check_field("irq_raise", want.irq_raise, res_ch.irq_raise);
					check_field("irq_flag", want.irq_flag, res_ch.irq_flag);
					check_field("active", want.active, res_ch.active);
					results_checked++;
				end
				fetch_count += res_ch.fetched;
				irq_count += res_ch.irq_raise;
				if (res_ch.level == dsc_pkg::LEVEL_MAX)
					peak_seen = 1'b1;
			end
		end
	end

	// Result receiver: shifting stall patterns plus long hold-offs on request
	initial begin : res_stall
		stall_mode_t mode;
		int mode_left;
		int hold_left;
		int holds_served;
		mode = STALL_NONE;
		mode_left = 0;
		hold_left = 0;
		holds_served = 0;
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (holds_served != holds_asked) begin
				holds_served = holds_asked;
				hold_left = 60;
			end
			if (mode_left == 0) begin
				mode = stall_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(20, 60);
			end
			mode_left--;
			if (hold_left > 0) begin
				hold_left--;
				res_ch.ready <= 1'b0;
			end else begin
				case (mode)
					STALL_NONE:  res_ch.ready <= 1'b1;
					STALL_LIGHT: res_ch.ready <= ($urandom_range(0, 3) != 0);
					STALL_HEAVY: res_ch.ready <= ($urandom_range(0, 3) == 0);
					default:     res_ch.ready <= (mode_left % 3 != 0);
				endcase
			end
		end
	end

	// Run limit
	initial begin
		#2000000;
		$display("delta_sample_channel_test failed");
		$finish;
	end

	initial begin : stimulus
		dsc_pkg::in_item_t rq;
		int n_items;
		int byte_mode;
		int pick;
		logic [8:0]  period;
		logic        loop_on;
		logic        irq_on;
		logic [15:0] start;
		logic [11:0] length;

		arst_n <= 1'b0;
		cmd_ch.valid <= 1'b0;
		cmd_ch.req_type <= dsc_pkg::REQ_TICK;
		cmd_ch.enable <= 1'b0;
		cmd_ch.fetched_byte <= 8'h00;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= dsc_pkg::CFG_TIMER_PERIOD;
		cfg_ch.data <= '0;
		pin_on <= 1'b0;
		pin_value <= NO_PIN;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		foreach (directed_rows[i]) begin
			if (directed_rows[i].is_cfg) begin
				wait_drain();
				write_register(directed_rows[i].idx, directed_rows[i].wdata);
			end else begin
				send_request(directed_rows[i].req, directed_rows[i].pinned,
					directed_rows[i].pin);
			end
		end

		// random phases, each under its own settings
		for (int phase = 0; phase < 9; phase++) begin
			wait_drain();

			// pick settings, forcing the extremes in a few phases
			if (phase == 2 || phase == 3)
				period = 9'd0;
			else if (phase == 4)
				period = 9'd511;
			else if (phase >= 5 && $urandom_range(0, 7) == 0)
				period = 9'($urandom_range(0, 511));
			else if ($urandom_range(0, 3) == 0)
				period = 9'($urandom_range(3, 40));
			else
				period = 9'($urandom_range(0, 2));
			loop_on = (phase >= 1 && phase <= 3) ? 1'b1 : (phase == 7 || phase == 6) ? 1'b0
				: 1'($urandom_range(0, 1));
			irq_on = (phase == 0 || phase == 6) ? 1'b1 : 1'($urandom_range(0, 1));
			case ($urandom_range(0, 5))
				0: start = 16'hFFFF;
				1: start = 16'hFFFE;
				2: start = 16'h0000;
				3: start = 16'h8000;
				4: start = 16'h7FFF;
				default: start = 16'($urandom_range(0, 65535));
			endcase
			if (phase == 2) start = 16'hFFFF;
			if (phase == 3) start = 16'h0000;
			case ($urandom_range(0, 4))
				0: length = 12'd0;
				1: length = 12'd1;
				2: length = 12'd2;
				3: length = 12'($urandom_range(1, 8));
				default: length = 12'($urandom_range(9, 40));
			endcase
			if (phase == 2) length = 12'd2;
			if (phase == 3) length = 12'd3;
			if (phase == 5) length = 12'd4095;
			if (phase == 6) length = 12'($urandom_range(1, 3));

			write_register(dsc_pkg::CFG_TIMER_PERIOD, {7'd0, period});
			write_register(dsc_pkg::CFG_LOOP_ENABLE, {15'd0, loop_on});
			write_register(dsc_pkg::CFG_IRQ_ARM, {15'd0, irq_on});
			write_register(dsc_pkg::CFG_START_ADDRESS, start);
			write_register(dsc_pkg::CFG_SAMPLE_BYTES, {4'd0, length});
			phases_run++;

			// a soft reset that keeps an odd level after the falling sweep
			if (phase == 4)
				send_request('{dsc_pkg::REQ_SOFT_RESET, 1'b1, 8'($urandom)}, 1'b0, NO_PIN);
			send_request('{dsc_pkg::REQ_STATUS, 1'b1, 8'($urandom)}, 1'b0, NO_PIN);

			n_items = (phase == 2) ? 100 : (phase == 3) ? 80 : 60;
			byte_mode = (phase == 2) ? 1 : (phase == 3) ? 2 : $urandom_range(0, 3);
			for (int k = 0; k < n_items; k++) begin
				if ((phase == 2 || phase == 6) && k == 10)
					holds_asked++;
				rq.enable = 1'($urandom_range(0, 1));
				case (byte_mode)
					1: rq.fetched_byte = 8'hFF;
					2: rq.fetched_byte = 8'h00;
					default: rq.fetched_byte = 8'($urandom);
				endcase
				// sweeps run on ticks alone; other phases mix in control requests
				pick = (phase == 2 || phase == 3) ? 0 : $urandom_range(0, 99);
				if (pick < 82) begin
					rq.req_type = dsc_pkg::REQ_TICK;
				end else if (pick < 89) begin
					rq.req_type = dsc_pkg::REQ_STATUS;
					rq.enable = 1'b1;
				end else if (pick < 93) begin
					rq.req_type = dsc_pkg::REQ_STATUS;
					rq.enable = 1'b0;
				end else if (pick < 97) begin
					rq.req_type = dsc_pkg::REQ_SOFT_RESET;
				end else begin
					rq.req_type = REQ_UNUSED;
				end
				send_request(rq, 1'b0, NO_PIN);
			end
		end

		wait_drain();
		$display("Covered %0d requests in %0d random setting phases plus the directed table;",
			requests_taken, phases_run);
		$display("%0d results checked, %0d byte fetches, %0d interrupts, full-scale level %s.",
			results_checked, fetch_count, irq_count, peak_seen ? "reached" : "not reached");
		if (mismatches == 0)
			$display("delta_sample_channel_test passed");
		else
			$display("delta_sample_channel_test failed");
		$finish;
	end

endmodule
